### rtl/core/trmt_pkg.sv
// shared types and constants for the time range membership table
`default_nettype none

package trmt_pkg;

    localparam int MAX_RANGES = 16;
    localparam int CNT_W = $clog2(MAX_RANGES + 1);
    localparam int STORED_COUNT_W = 5;
    localparam int TIME_W = 64;

    typedef logic [1:0] req_type_t;
    typedef logic signed [TIME_W-1:0] time_t;
    typedef logic [STORED_COUNT_W-1:0] stored_count_t;
    typedef logic [CNT_W-1:0] cnt_t;

    localparam req_type_t REQ_CLEAR  = 2'd0;
    localparam req_type_t REQ_APPEND = 2'd1;
    localparam req_type_t REQ_QUERY  = 2'd2;

    // query token walking down the cell chain
    typedef struct packed {
        logic  valid;
        logic  hit;
        time_t qt;
    } token_t;

endpackage

`default_nettype wire

### rtl/core/trmt_req_if.sv
// request channel interface for the time range membership table
`default_nettype none

interface trmt_req_if;
    logic                valid;
    logic                ready;
    trmt_pkg::req_type_t req_type;
    trmt_pkg::time_t     start_time;
    trmt_pkg::time_t     end_time;
    trmt_pkg::time_t     query_time;

    modport source (
        output valid,
        output req_type,
        output start_time,
        output end_time,
        output query_time,
        input  ready
    );

    modport sink (
        input  valid,
        input  req_type,
        input  start_time,
        input  end_time,
        input  query_time,
        output ready
    );
endinterface

`default_nettype wire

### rtl/core/trmt_res_if.sv
// result channel interface for the time range membership table
`default_nettype none

interface trmt_res_if;
    logic                    valid;
    logic                    ready;
    logic                    append_accepted;
    logic                    in_range;
    trmt_pkg::stored_count_t stored_count;

    modport source (
        output valid,
        output append_accepted,
        output in_range,
        output stored_count,
        input  ready
    );

    modport sink (
        input  valid,
        input  append_accepted,
        input  in_range,
        input  stored_count,
        output ready
    );
endinterface

`default_nettype wire

### rtl/core/trmt_cell.sv
// one table cell: holds a range, shifts it on append, tests the passing query token
`default_nettype none

module trmt_cell (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             occupied,
    input  wire logic             shift_en,
    input  wire trmt_pkg::time_t  start_in,
    input  wire trmt_pkg::time_t  end_in,
    output      trmt_pkg::time_t  start_out,
    output      trmt_pkg::time_t  end_out,
    input  wire trmt_pkg::token_t tok_in,
    output      trmt_pkg::token_t tok_out
);
    import trmt_pkg::*;

    time_t  start_reg;
    time_t  end_reg;
    logic   tok_valid_reg;
    logic   tok_hit_reg;
    time_t  tok_qt_reg;
    logic   covers;

    // entry storage, no reset: only cells below the count are ever looked at
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            start_reg <= start_in;
            end_reg   <= end_in;
        end
    end

    // both ends inclusive
    assign covers = occupied
                 && ($signed(start_reg) <= $signed(tok_in.qt))
                 && ($signed(tok_in.qt) <= $signed(end_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= tok_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_hit_reg <= tok_in.hit || covers;
        tok_qt_reg  <= tok_in.qt;
    end

    assign start_out     = start_reg;
    assign end_out       = end_reg;
    assign tok_out.valid = tok_valid_reg;
    assign tok_out.hit   = tok_hit_reg;
    assign tok_out.qt    = tok_qt_reg;

endmodule

`default_nettype wire

### rtl/core/time_range_membership_table.sv
// top level of the time range membership table: request decode, cell chain, result staging
`default_nettype none

// Holds up to MAX_RANGES (16) inclusive time ranges of signed 64-bit millisecond
// timestamps in a row of cells. Every request transfer gives exactly one result
// transfer, in order. A clear empties the table; an append is stored only when
// the table is not full, the start is positive and the end is later than the
// start, and append_accepted tells whether it was; a query answers whether the
// timestamp lies in any stored range (an empty table matches everything).
// stored_count is the count after the request, shown in 5 bits. Request kind 3
// changes nothing and returns zeros with the current count. Timing: clear and
// append finish in the cycle of their transfer, so they can follow one per cycle
// while the result side keeps up, and their result passes through the staging
// register and then the output register. A query walks a token down the chain,
// one cell per cycle, and holds the request side until the token leaves the last
// cell; its result then takes the same path. Appends shift the cell row by one,
// so the stored order is newest first. A finished result waits in the staging
// register while the output register is held; the request side stalls only while
// a query walks the chain or while both registers are full and res.ready is low.

module time_range_membership_table (
    input wire logic clk,
    input wire logic rst_n,
    trmt_req_if.sink   req,
    trmt_res_if.source res
);
    import trmt_pkg::*;

    // count of stored ranges
    cnt_t   cnt_reg;
    cnt_t   cnt_next;

    // query in flight in the chain
    logic   busy_reg;

    // staging register between the table and the output register
    logic          stage_valid_reg;
    logic          stage_accepted_reg;
    logic          stage_hit_reg;
    stored_count_t stage_count_reg;

    // output register
    logic          out_valid_reg;
    logic          out_accepted_reg;
    logic          out_hit_reg;
    stored_count_t out_count_reg;

    logic   req_xfer;
    logic   is_clear;
    logic   is_append;
    logic   is_query;
    logic   append_ok;
    logic   shift_en;
    logic   out_free;
    logic   stage_move;
    logic   query_done;

    token_t tok_chain   [0:MAX_RANGES];
    time_t  start_chain [0:MAX_RANGES];
    time_t  end_chain   [0:MAX_RANGES];
    logic   occupied    [0:MAX_RANGES-1];

    // request kind decode
    always_comb
    begin
        is_clear  = 1'b0;
        is_append = 1'b0;
        is_query  = 1'b0;
        unique case (req.req_type)
            REQ_CLEAR:  is_clear  = 1'b1;
            REQ_APPEND: is_append = 1'b1;
            REQ_QUERY:  is_query  = 1'b1;
            default:    ;
        endcase
    end

    // output register frees when empty or taken this cycle
    assign out_free   = !out_valid_reg || res.ready;
    assign stage_move = stage_valid_reg && out_free;

    // take a request unless a query walks the chain or the stage is stuck
    assign req.ready = !busy_reg && (!stage_valid_reg || out_free);
    assign req_xfer  = req.valid && req.ready;

    // not full, start positive, end strictly later than start
    assign append_ok = (cnt_reg < CNT_W'(MAX_RANGES))
                    && ($signed(req.start_time) > $signed(TIME_W'(0)))
                    && ($signed(req.end_time) > $signed(req.start_time));

    assign shift_en = req_xfer && is_append && append_ok;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (req_xfer && is_clear)
        begin
            cnt_next = '0;
        end
        else if (shift_en)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    // head of the chain: new entry and a fresh query token
    // an empty table seeds the token with a hit
    assign start_chain[0]   = req.start_time;
    assign end_chain[0]     = req.end_time;
    assign tok_chain[0].valid = req_xfer && is_query;
    assign tok_chain[0].hit   = (cnt_reg == '0);
    assign tok_chain[0].qt    = req.query_time;

    // row of cells; cell k is in use while k is below the count
    for (genvar k = 0; k < MAX_RANGES; k++)
    begin : g_cell
        assign occupied[k] = CNT_W'(k) < cnt_reg;

        trmt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .occupied  (occupied[k]),
            .shift_en  (shift_en),
            .start_in  (start_chain[k]),
            .end_in    (end_chain[k]),
            .start_out (start_chain[k+1]),
            .end_out   (end_chain[k+1]),
            .tok_in    (tok_chain[k]),
            .tok_out   (tok_chain[k+1])
        );
    end

    // token leaving the last cell carries the answer
    assign query_done = tok_chain[MAX_RANGES].valid;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg         <= '0;
            busy_reg        <= 1'b0;
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;

            if (query_done)
            begin
                busy_reg <= 1'b0;
            end
            else if (req_xfer && is_query)
            begin
                busy_reg <= 1'b1;
            end

            // stage drains first, a new result may refill it in the same cycle
            if (stage_move)
            begin
                stage_valid_reg <= 1'b0;
            end
            if (query_done || (req_xfer && !is_query))
            begin
                stage_valid_reg <= 1'b1;
            end

            if (stage_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (query_done)
        begin
            stage_accepted_reg <= 1'b0;
            stage_hit_reg      <= tok_chain[MAX_RANGES].hit;
            stage_count_reg    <= STORED_COUNT_W'(cnt_reg);
        end
        else if (req_xfer && !is_query)
        begin
            stage_accepted_reg <= shift_en;
            stage_hit_reg      <= 1'b0;
            stage_count_reg    <= STORED_COUNT_W'(cnt_next);
        end

        if (stage_move)
        begin
            out_accepted_reg <= stage_accepted_reg;
            out_hit_reg      <= stage_hit_reg;
            out_count_reg    <= stage_count_reg;
        end
    end

    assign res.valid           = out_valid_reg;
    assign res.append_accepted = out_accepted_reg;
    assign res.in_range        = out_hit_reg;
    assign res.stored_count    = out_count_reg;

`ifndef SYNTH
    // the count never runs past the table size
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_RANGES))
        else $error("range count above table size");

    // a stored append grows the count by exactly one
    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        shift_en |=> (cnt_reg == $past(cnt_reg) + CNT_W'(1)))
        else $error("append did not grow the count by one");

    // the table does not change while a query walks the chain
    a_stable_in_query: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |=> $stable(cnt_reg))
        else $error("count changed during a query");

    // a query in flight and a staged result never coexist
    a_busy_stage: assert property (@(posedge clk) disable iff (!rst_n)
        !(busy_reg && stage_valid_reg))
        else $error("staged result while a query is in flight");

    // a token reaches the end of the chain only for a query in flight
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        query_done |-> busy_reg)
        else $error("query token without a query in flight");
`endif

endmodule

`default_nettype wire

### tb/trmt_table_checker.sv
`timescale 1ns / 1ps
// scoreboard for the time range membership table: predicts every result and compares it

module trmt_table_checker (
    input  logic clk,
    input  logic rst_n,
    trmt_req_if  req,
    trmt_res_if  res,
    output int   errors,
    output int   pending
);
    import trmt_pkg::*;

    typedef struct packed {
        logic          append_accepted;
        logic          in_range;
        stored_count_t stored_count;
    } table_result_t;

    // shadow copy of the table; order of entries does not matter for a query
    time_t shadow_start [MAX_RANGES];
    time_t shadow_end   [MAX_RANGES];
    int    shadow_count = 0;

    table_result_t expected_results [$];
    int            mismatch_count = 0;
    int            outstanding = 0;

    assign errors  = mismatch_count;
    assign pending = outstanding;

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic table_result_t apply_request(
        input req_type_t kind,
        input time_t     lo,
        input time_t     hi,
        input time_t     probe
    );
        table_result_t r;
        r = '0;
        case (kind)
            REQ_CLEAR:
                shadow_count = 0;
            REQ_APPEND:
                if (shadow_count < MAX_RANGES && lo > 0 && hi > lo)
                begin
                    shadow_start[shadow_count] = lo;
                    shadow_end[shadow_count]   = hi;
                    shadow_count++;
                    r.append_accepted = 1'b1;
                end
            REQ_QUERY:
            begin
                // empty table matches everything, ends are inclusive
                r.in_range = (shadow_count == 0);
                for (int i = 0; i < shadow_count; i++)
                    if (shadow_start[i] <= probe && probe <= shadow_end[i])
                        r.in_range = 1'b1;
            end
            default: ;
        endcase
        r.stored_count = stored_count_t'(shadow_count);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        table_result_t want;
        if (!rst_n)
        begin
            shadow_count = 0;
            expected_results.delete();
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result transfer with no request pending");
                else
                begin
                    want = expected_results.pop_front();
                    if (res.append_accepted !== want.append_accepted)
                        report_mismatch($sformatf("append_accepted got %b want %b",
                            res.append_accepted, want.append_accepted));
                    if (res.in_range !== want.in_range)
                        report_mismatch($sformatf("in_range got %b want %b",
                            res.in_range, want.in_range));
                    if (res.stored_count !== want.stored_count)
                        report_mismatch($sformatf("stored_count got %0d want %0d",
                            res.stored_count, want.stored_count));
                end
            end
            if (req.valid && req.ready)
                expected_results.push_back(apply_request(req.req_type, req.start_time,
                    req.end_time, req.query_time));
        end
        outstanding = expected_results.size();
    end

endmodule

### tb/time_range_membership_table_tb.sv
`timescale 1ns / 1ps
// top of the testbench: clock, reset, request and result traffic, verdict

module time_range_membership_table_tb;
    import trmt_pkg::*;

    // request kind 3 has no meaning but must leave the table alone
    localparam req_type_t REQ_UNUSED = 2'd3;

    localparam time_t T_MIN = 64'sh8000_0000_0000_0000;
    localparam time_t T_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

    localparam int RANDOM_REQUESTS = 1900;
    // cycles with no transfer on either channel before the run is declared hung
    localparam int STALL_LIMIT = 2000;
    // a query holds the request side while its token walks the cell chain
    localparam int QUERY_CYCLES = MAX_RANGES + 1;

    typedef struct {
        req_type_t kind;
        time_t     range_lo;
        time_t     range_hi;
        time_t     probe;
    } request_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    trmt_req_if req_ch ();
    trmt_res_if res_ch ();

    int sender_idle_pct = 0;
    int receiver_idle_pct = 0;
    int errors;
    int pending;
    int quiet_cycles = 0;

    // bounds of recently sent good ranges, used to aim queries at range edges
    time_t recent_bounds [$];

    time_range_membership_table uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    trmt_table_checker table_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .res     (res_ch),
        .errors  (errors),
        .pending (pending)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // result side: random back-pressure, changed on the falling edge only
    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            res_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // hang detector: any transfer on either side restarts the count
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic request_t make_request(
        input req_type_t kind,
        input time_t     lo,
        input time_t     hi,
        input time_t     probe
    );
        request_t r;
        r.kind     = kind;
        r.range_lo = lo;
        r.range_hi = hi;
        r.probe    = probe;
        return r;
    endfunction

    // full 64-bit value, now and then one of the corner values
    function automatic time_t wide_value();
        case ($urandom_range(11))
            0: return T_MIN;
            1: return T_MAX;
            2: return '0;
            3: return -64'sd1;
            4: return 64'sd1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic request_t random_request();
        request_t r;
        int pick;
        int flavor;
        pick       = $urandom_range(99);
        flavor     = $urandom_range(9);
        // fields a request does not use still carry noise
        r.range_lo = wide_value();
        r.range_hi = wide_value();
        r.probe    = wide_value();
        if (pick < 2)
            r.kind = REQ_CLEAR;
        else if (pick < 5)
            r.kind = REQ_UNUSED;
        else if (pick < 50)
        begin
            r.kind = REQ_APPEND;
            if (flavor < 7)
            begin
                // well-formed pair in a narrow window so queries hit and miss
                r.range_lo = time_t'($urandom_range(1000, 1));
                r.range_hi = r.range_lo + time_t'($urandom_range(60, 1));
                recent_bounds.push_back(r.range_lo);
                recent_bounds.push_back(r.range_hi);
                if (recent_bounds.size() > 32)
                begin
                    void'(recent_bounds.pop_front());
                    void'(recent_bounds.pop_front());
                end
            end
            else if (flavor < 9)
            begin
                // start around zero, end at or before the start
                r.range_lo = time_t'($urandom_range(40)) - 20;
                r.range_hi = r.range_lo - time_t'($urandom_range(2));
            end
        end
        else
        begin
            r.kind = REQ_QUERY;
            if (flavor < 5)
                r.probe = time_t'($urandom_range(1100)) - 50;
            else if (flavor < 8 && recent_bounds.size() > 0)
                r.probe = recent_bounds[$urandom_range(recent_bounds.size() - 1)]
                          + time_t'($urandom_range(2)) - 1;
        end
        return r;
    endfunction

    // drive one request from the falling edge and wait for its transfer
    task automatic send_request(input request_t item);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= item.kind;
        req_ch.start_time <= item.range_lo;
        req_ch.end_time   <= item.range_hi;
        req_ch.query_time <= item.probe;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    task automatic send_random(input int count);
        repeat (count)
            send_request(random_request());
    endtask

    initial
    begin
        req_ch.valid      = 1'b0;
        req_ch.req_type   = REQ_CLEAR;
        req_ch.start_time = '0;
        req_ch.end_time   = '0;
        req_ch.query_time = '0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // phase one: sender mostly busy, receiver stalls half the time
        sender_idle_pct   = 12;
        receiver_idle_pct = 50;

        // empty table matches even the most negative timestamp
        send_request(make_request(REQ_QUERY, '0, '0, T_MIN));
        // refused pairs: zero start, negative start, empty span, reversed span
        send_request(make_request(REQ_APPEND, '0, 64'sd10, '0));
        send_request(make_request(REQ_APPEND, T_MIN, T_MAX, '0));
        send_request(make_request(REQ_APPEND, 64'sd10, 64'sd10, '0));
        send_request(make_request(REQ_APPEND, 64'sd10, 64'sd9, '0));
        // one good range, then its inclusive edges and just past the end
        send_request(make_request(REQ_APPEND, 64'sd10, 64'sd20, '0));
        send_request(make_request(REQ_QUERY, '0, '0, 64'sd10));
        send_request(make_request(REQ_QUERY, '0, '0, 64'sd20));
        send_request(make_request(REQ_QUERY, '0, '0, 64'sd21));
        // unused kind with every field bit set
        send_request(make_request(REQ_UNUSED, -64'sd1, -64'sd1, -64'sd1));
        // fill the table, the last range sitting at the top of the time axis
        for (int i = 0; i < MAX_RANGES - 1; i++)
            if (i == MAX_RANGES - 2)
                send_request(make_request(REQ_APPEND, T_MAX - 1, T_MAX, '0));
            else
                send_request(make_request(REQ_APPEND, time_t'(100 * i + 1),
                    time_t'(100 * i + 50), '0));
        // full table refuses an otherwise good pair
        send_request(make_request(REQ_APPEND, 64'sd1, T_MAX, '0));
        send_request(make_request(REQ_QUERY, '0, '0, T_MAX));
        send_request(make_request(REQ_CLEAR, -64'sd1, -64'sd1, -64'sd1));

        send_random(RANDOM_REQUESTS / 3);

        // phase two: sender idles half the time, receiver rarely stalls
        sender_idle_pct   = 50;
        receiver_idle_pct = 12;
        send_random(RANDOM_REQUESTS / 3);

        // phase three: full rate on both sides
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        send_random(RANDOM_REQUESTS - 2 * (RANDOM_REQUESTS / 3));

        @(negedge clk);
        req_ch.valid <= 1'b0;

        // drain, then give any stray result time to show up
        while (pending != 0)
            @(posedge clk);
        repeat (2 * QUERY_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
